@@ src/sdt_pkg.sv @@
// ----------------------------------------------------------------------------
// sdt_pkg: shared types and constants
// Constants and the per-cell record used by the device table chain.
// ----------------------------------------------------------------------------
`default_nettype none
package sdt_pkg;
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int REPORT_MAX_DEF  = 8;
  localparam int ADDR_W  = 48;
  localparam int LEVEL_W = 8;
  localparam int KIND_W  = 8;
  localparam int TOTAL_W = 16;
  localparam int DCNT_W  = 5;

  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_REPORT = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0]         addr;
    logic signed [LEVEL_W-1:0] level;
    logic [KIND_W-1:0]         kind;
  } entry_t;
endpackage
`default_nettype wire

@@ src/sdt_cell.sv @@
// ----------------------------------------------------------------------------
// sdt_cell: one table slot
// Holds one entry; loads a new value, or shifts in its neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none
module sdt_cell
  import sdt_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   load,
  input  wire entry_t load_val,
  input  wire logic   shift,
  input  wire entry_t shift_in,
  output entry_t      ent
);
  entry_t ent_r;
  always_ff @(posedge clk) begin
    if (load) ent_r <= load_val;
    else if (shift) ent_r <= shift_in;
  end
  assign ent = ent_r;
endmodule
`default_nettype wire

@@ src/strongest_device_table_top.sv @@
// ----------------------------------------------------------------------------
// strongest_device_table_top: window table of strongest radio devices
// Record sightings in a chain of slot cells, report them sorted strongest first.
// ----------------------------------------------------------------------------
// Usage:
//  in_* channel: action 0 records a sighting, action 1 requests a report.
//  out_* channel: a report yields min(entries, REPORT_MAX) transactions, or
//  one transaction with entry_valid low when the table is empty; last marks
//  the final one. Records yield nothing.
//  One item is worked at a time. A record walks the cell chain with a
//  rotating scan: the chain rotates by one cell per cycle, first a full
//  rotation to look up the address and find the weakest slot, then a step
//  to pick the target while the chain holds, then a rotation to the chosen
//  slot, which is then written. A report runs a selection pass per shown
//  entry (a full rotation of the chain, then an emit step) and then waits
//  for the last output handshake.
//  The output register holds a transaction while out_stall is high; the
//  scan waits until it is taken.
//  Reset (rst_n low, synchronous) empties the table and the count; cell
//  contents are not cleared, only the fill and sighting counts are.
// ----------------------------------------------------------------------------
`default_nettype none
module strongest_device_table_top
  import sdt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int REPORT_MAX  = REPORT_MAX_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_action,
  input  wire logic [ADDR_W-1:0]   in_device_addr,
  input  wire logic signed [LEVEL_W-1:0] in_signal_level,
  input  wire logic [KIND_W-1:0]   in_ad_kind,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_entry_valid,
  output logic [ADDR_W-1:0]        out_out_addr,
  output logic signed [LEVEL_W-1:0] out_out_level,
  output logic [KIND_W-1:0]        out_out_kind,
  output logic [DCNT_W-1:0]        out_distinct_count,
  output logic [TOTAL_W-1:0]       out_sighting_count,
  output logic                     out_last
);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int RW = $clog2(REPORT_MAX + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_SCAN = 6'b000010, S_SEEK = 6'b000100,
    S_SEL  = 6'b001000, S_EMIT = 6'b010000, S_WAIT = 6'b100000
  } state_t;

  state_t state_r;
  entry_t cells [TABLE_DEPTH];
  logic   shift;
  logic   load0;
  entry_t load_val;

  // chain: cell 0 takes from the last cell, a full rotation each pass
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    sdt_cell u_cell (
      .clk(clk), .load((g == 0) && load0), .load_val(load_val),
      .shift(shift), .shift_in(cells[(g + TABLE_DEPTH - 1) % TABLE_DEPTH]),
      .ent(cells[g])
    );
  end

  // logical index of cell 0 is tracked by rotation offset
  logic [IW-1:0] rot_r;       // logical index held in physical cell 0
  logic [CW-1:0] used_r;
  logic [TOTAL_W-1:0] total_r;
  logic [CW-1:0] step_r;
  entry_t req_r;
  logic found_r;
  logic [IW-1:0] tgt_r;       // target logical index
  logic signed [LEVEL_W-1:0] best_r;
  logic [IW-1:0] bidx_r;
  logic [TABLE_DEPTH-1:0] taken_r;
  logic [RW-1:0] shown_r, nshow_r;
  logic [CW-1:0] n_r;
  logic [TOTAL_W-1:0] tot_snap_r;
  entry_t best_ent_r;

  logic [IW-1:0] cur_idx;
  logic cur_used;
  logic seek_pick;            // first SEEK cycle: target is chosen, chain holds
  assign cur_idx   = rot_r;
  assign cur_used  = {1'b0, cur_idx} < used_r;
  assign seek_pick = (state_r == S_SEEK) && (step_r == CW'(TABLE_DEPTH));

  logic ovld_r;
  entry_t oent_r;
  logic oev_r, olast_r;
  logic o_load;

  // new output transaction: empty report, or one sorted entry
  assign o_load = ((state_r == S_IDLE) && in_valid && (in_action == ACT_REPORT) &&
                   (used_r == '0)) ||
                  ((state_r == S_EMIT) && (!ovld_r || !out_stall));

  assign in_stall = (state_r != S_IDLE);
  assign shift = (state_r == S_SCAN) || (state_r == S_SEL) ||
                 ((state_r == S_SEEK) && !seek_pick && (cur_idx != tgt_r));
  assign load0 = (state_r == S_SEEK) && !seek_pick && (cur_idx == tgt_r);
  assign load_val = (found_r) ?
      '{addr: req_r.addr,
        level: (req_r.level > cells[0].level) ? req_r.level : cells[0].level,
        kind: req_r.kind} : req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; rot_r <= '0; used_r <= '0; total_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= o_load || (ovld_r && out_stall);
      if (shift) rot_r <= (rot_r == '0) ? IW'(TABLE_DEPTH - 1) : rot_r - 1'b1;
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          req_r <= '{addr: in_device_addr, level: in_signal_level, kind: in_ad_kind};
          step_r <= '0; found_r <= 1'b0;
          best_r <= {1'b0, {(LEVEL_W-1){1'b1}}}; bidx_r <= '0;
          if (in_action == ACT_RECORD) begin
            if (total_r != '1) total_r <= total_r + 1'b1;
            state_r <= S_SCAN;
          end else begin
            n_r <= used_r; tot_snap_r <= total_r; taken_r <= '0;
            shown_r <= '0; best_ent_r <= '0;
            nshow_r <= (used_r > CW'(REPORT_MAX)) ? RW'(REPORT_MAX) : RW'(used_r);
            if (used_r == '0) begin
              oent_r <= '0; oev_r <= 1'b0; olast_r <= 1'b1;
              state_r <= S_WAIT;
            end else state_r <= S_SEL;
          end
        end
        S_SCAN: begin
          // look at logical entry cur_idx in cell 0 this cycle
          if (cur_used && !found_r && cells[0].addr == req_r.addr) begin
            found_r <= 1'b1; tgt_r <= cur_idx;
          end
          if (cells[0].level < best_r ||
              ({1'b0, cur_idx} == CW'(0) && step_r == '0) ||
              (cells[0].level == best_r && cur_idx < bidx_r)) begin
            best_r <= cells[0].level; bidx_r <= cur_idx;
          end
          step_r <= step_r + 1'b1;
          if (step_r == CW'(TABLE_DEPTH - 1)) state_r <= S_SEEK;
        end
        S_SEEK: begin
          // pick target once on entry (found / free / weakest), or drop the record
          if (seek_pick) begin
            step_r <= '0;
            if (!found_r) begin
              if (used_r < CW'(TABLE_DEPTH)) begin
                tgt_r <= IW'(used_r); used_r <= used_r + 1'b1;
              end else if (best_r < req_r.level) tgt_r <= bidx_r;
              else state_r <= S_IDLE;
            end
          end else if (cur_idx == tgt_r) state_r <= S_IDLE;
        end
        S_SEL: begin
          if (cur_used && !taken_r[cur_idx] &&
              (step_r == '0 || cells[0].level > best_r ||
               (cells[0].level == best_r && cur_idx < bidx_r) || !found_r)) begin
            best_r <= cells[0].level; bidx_r <= cur_idx;
            best_ent_r <= cells[0]; found_r <= 1'b1;
          end
          step_r <= step_r + 1'b1;
          if (step_r == CW'(TABLE_DEPTH - 1)) state_r <= S_EMIT;
        end
        S_EMIT: if (!ovld_r || !out_stall) begin
          oent_r <= best_ent_r; oev_r <= 1'b1;
          olast_r <= (shown_r + 1'b1 == nshow_r);
          taken_r[bidx_r] <= 1'b1;
          shown_r <= shown_r + 1'b1; step_r <= '0; found_r <= 1'b0;
          if (shown_r + 1'b1 == nshow_r) state_r <= S_WAIT;
          else state_r <= S_SEL;
        end
        S_WAIT: if (ovld_r && !out_stall) begin
          used_r <= '0; total_r <= '0; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = ovld_r;
  assign out_entry_valid    = oev_r;
  assign out_out_addr       = oent_r.addr;
  assign out_out_level      = oent_r.level;
  assign out_out_kind       = oent_r.kind;
  assign out_distinct_count = DCNT_W'(n_r);
  assign out_sighting_count = tot_snap_r;
  assign out_last           = olast_r;

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(TABLE_DEPTH)) else $error("fill count overflow");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accepted while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && out_stall) |=> ovld_r) else $error("result dropped");
endmodule
`default_nettype wire
